>>> src/key_sort_engine_defines.svh
// ----------------------------------------------------------------------------
// key_sort_engine_defines.svh
// Assertion macros shared by the key sort engine RTL.
// ----------------------------------------------------------------------------
`ifndef KEY_SORT_ENGINE_DEFINES_SVH
`define KEY_SORT_ENGINE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KSE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("key_sort_engine: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define KSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("key_sort_engine: next-cycle check failed");

`endif

>>> src/ksort_pkg.sv
// ----------------------------------------------------------------------------
// ksort_pkg
// Shared constants and types of the key sort engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ksort_pkg;

    // Fixed widths of the transaction fields.
    localparam int KEY_PORT_W = 32;
    localparam int IDX_W      = 6;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_ITEMS = 64;
    localparam int DEF_KEY_WIDTH = 32;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_cmd;

    // Status a cell hands to its right-hand neighbour.
    typedef struct packed {
        logic valid;
        logic keep;
    } t_cell_link;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        S_LOAD = 2'b01,
        S_EMIT = 2'b10
    } t_state;

endpackage

`default_nettype wire

>>> src/ksort_cell.sv
// ----------------------------------------------------------------------------
// ksort_cell
// One cell of the insertion chain: holds a key and its arrival index.
// ----------------------------------------------------------------------------
`default_nettype none

module ksort_cell
    import ksort_pkg::*;
#(
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_cmd            i_cmd,
    input  wire logic [KEY_WIDTH-1:0] i_new_key,
    input  wire logic [IDX_W-1:0]     i_new_idx,
    input  wire t_cell_link           i_left_link,
    input  wire logic [KEY_WIDTH-1:0] i_left_key,
    input  wire logic [IDX_W-1:0]     i_left_idx,
    input  wire logic                 i_right_valid,
    input  wire logic [KEY_WIDTH-1:0] i_right_key,
    input  wire logic [IDX_W-1:0]     i_right_idx,
    output t_cell_link                o_link,
    output logic [KEY_WIDTH-1:0]      o_key,
    output logic [IDX_W-1:0]          o_idx
);

    logic                 r_valid;
    logic                 n_valid;
    logic [KEY_WIDTH-1:0] r_key;
    logic [KEY_WIDTH-1:0] n_key;
    logic [IDX_W-1:0]     r_idx;
    logic [IDX_W-1:0]     n_idx;
    logic                 w_keep;

    // A stored key not above the new one stays put, so equal keys keep arrival order.
    assign w_keep = r_valid && (r_key <= i_new_key);

    assign o_link = '{valid: r_valid, keep: w_keep};
    assign o_key  = r_key;
    assign o_idx  = r_idx;

    // Next contents: pull from the right when draining, insert or move right when loading.
    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_idx   = r_idx;
        if (i_cmd.shift) begin
            n_valid = i_right_valid;
            n_key   = i_right_key;
            n_idx   = i_right_idx;
        end else if (i_cmd.insert && !w_keep) begin
            if (i_left_link.keep) begin
                n_valid = 1'b1;
                n_key   = i_new_key;
                n_idx   = i_new_idx;
            end else begin
                n_valid = i_left_link.valid;
                n_key   = i_left_key;
                n_idx   = i_left_idx;
            end
        end
    end

    // Occupancy flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_idx <= n_idx;
    end

endmodule

`default_nettype wire

>>> src/key_sort_engine.sv
// The first sorted transaction is offered in the cycle after the last-marked input is
// accepted. Loading takes one key per cycle, draining one result per cycle while the
// output is not stalled, set by the insertion chain, which moves all cells together.
// Input is held off while draining.
// Reset (synchronous, active low) empties all cells and returns to loading.
// ----------------------------------------------------------------------------
// key_sort_engine
// Batch sorter built as a chain of insertion cells with a small controller.
// ----------------------------------------------------------------------------
`default_nettype none

`include "key_sort_engine_defines.svh"

module key_sort_engine
    import ksort_pkg::*;
#(
    parameter int MAX_ITEMS = DEF_MAX_ITEMS,
    parameter int KEY_WIDTH = DEF_KEY_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [KEY_PORT_W-1:0] i_key,
    input  wire logic                  i_last,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [KEY_PORT_W-1:0]      o_sorted_key,
    output logic [IDX_W-1:0]           o_original_index,
    output logic                       o_final_res
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 w_in_acc;
    logic                 w_out_acc;
    logic                 w_has_room;
    t_cell_cmd            w_cmd;
    logic [KEY_WIDTH-1:0] w_new_key;
    logic [IDX_W-1:0]     w_new_idx;

    t_cell_link           c_link [MAX_ITEMS];
    logic [KEY_WIDTH-1:0] c_key  [MAX_ITEMS];
    logic [IDX_W-1:0]     c_idx  [MAX_ITEMS];

    // Handshakes.
    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = (r_state == S_EMIT);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = o_out_valid && !i_out_stall;
    assign w_has_room  = (r_count < CNT_W'(MAX_ITEMS));

    // Key is cut to the working width; index is the arrival position modulo 64.
    assign w_new_key = KEY_WIDTH'(i_key);
    assign w_new_idx = IDX_W'(r_count);

    // Cell commands.
    assign w_cmd = '{insert: w_in_acc && w_has_room, shift: w_out_acc};

    // Results come from the head of the chain.
    assign o_sorted_key     = KEY_PORT_W'(c_key[0]);
    assign o_original_index = c_idx[0];
    assign o_final_res      = (r_count == CNT_W'(1));

    // Controller: count keys while loading, count down while draining.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (w_has_room) begin
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_last) begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_acc) begin
                    n_count = r_count - CNT_W'(1);
                    if (r_count == CNT_W'(1)) begin
                        n_state = S_LOAD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
                n_count = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // Chain of cells; the left boundary always accepts the new key, the right one is empty.
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
        t_cell_link           w_left_link;
        logic [KEY_WIDTH-1:0] w_left_key;
        logic [IDX_W-1:0]     w_left_idx;
        logic                 w_right_valid;
        logic [KEY_WIDTH-1:0] w_right_key;
        logic [IDX_W-1:0]     w_right_idx;

        if (i == 0) begin : g_head
            assign w_left_link = '{valid: 1'b1, keep: 1'b1};
            assign w_left_key  = w_new_key;
            assign w_left_idx  = w_new_idx;
        end else begin : g_body
            assign w_left_link = c_link[i-1];
            assign w_left_key  = c_key[i-1];
            assign w_left_idx  = c_idx[i-1];
        end

        if (i == MAX_ITEMS - 1) begin : g_tail
            assign w_right_valid = 1'b0;
            assign w_right_key   = '0;
            assign w_right_idx   = '0;
        end else begin : g_next
            assign w_right_valid = c_link[i+1].valid;
            assign w_right_key   = c_key[i+1];
            assign w_right_idx   = c_idx[i+1];
        end

        ksort_cell #(
            .KEY_WIDTH (KEY_WIDTH)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_new_key     (w_new_key),
            .i_new_idx     (w_new_idx),
            .i_left_link   (w_left_link),
            .i_left_key    (w_left_key),
            .i_left_idx    (w_left_idx),
            .i_right_valid (w_right_valid),
            .i_right_key   (w_right_key),
            .i_right_idx   (w_right_idx),
            .o_link        (c_link[i]),
            .o_key         (c_key[i]),
            .o_idx         (c_idx[i])
        );
    end

    // Draining never runs with an empty count, and the head cell is then occupied.
    `KSE_ASSERT_NOW(a_emit_count, i_clk, i_rst_n, o_out_valid, (r_count != '0) && c_link[0].valid)
    // The final result returns the block to loading with an empty store.
    `KSE_ASSERT_NEXT(a_final_done, i_clk, i_rst_n, w_out_acc && o_final_res, (r_state == S_LOAD) && (r_count == '0) && !c_link[0].valid)
    // A stored key advances the count by one.
    `KSE_ASSERT_NEXT(a_load_count, i_clk, i_rst_n, w_in_acc && w_has_room, r_count == $past(r_count) + CNT_W'(1))
    // While loading, the head cell is occupied exactly when keys are held.
    `KSE_ASSERT_NOW(a_head_valid, i_clk, i_rst_n, r_state == S_LOAD, c_link[0].valid == (r_count != '0))

endmodule

`default_nettype wire

>>> tb/sv/tb_key_sort_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_key_sort_engine
// Self-checking testbench for the key sort engine. Sets of keys are loaded
// with random input gaps and output stalls. A scoreboard keeps its own copy of
// the loaded set, sorts it stably when the last-marked key is accepted, and
// compares every sorted transaction field by field against that prediction.
// ----------------------------------------------------------------------------

module tb_key_sort_engine;
    import ksort_pkg::*;

    localparam int STORE_DEPTH    = DEF_MAX_ITEMS;
    localparam int KEY_BITS       = DEF_KEY_WIDTH;
    localparam int TOTAL_ITEMS    = 310;
    localparam int QUIET_ITEMS    = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int REPORT_LIMIT   = 10;

    // One predicted sorted transaction.
    typedef struct packed {
        logic [KEY_PORT_W-1:0] key;
        logic [IDX_W-1:0]      pos;
        logic                  fin;
    } t_sorted_entry;

    // Holds the set being loaded and the sorted transactions still owed.
    class sorted_run_checker;
        logic [KEY_PORT_W-1:0] held_key[STORE_DEPTH];
        logic [IDX_W-1:0]      held_pos[STORE_DEPTH];
        int                    held_count;
        t_sorted_entry         owed_sorted[$];
        int                    fault_count;

        function new();
            held_count  = 0;
            fault_count = 0;
        endfunction

        function int pending();
            return owed_sorted.size();
        endfunction

        // Store an accepted key; a last-marked key releases the sorted set.
        function void load_key(logic [KEY_PORT_W-1:0] key, logic last);
            logic [KEY_PORT_W-1:0] k;
            logic [IDX_W-1:0]      p;
            t_sorted_entry         e;
            int                    j;
            if (held_count < STORE_DEPTH) begin
                held_key[held_count] =
                    KEY_PORT_W'(64'(key) & ((64'd1 << KEY_BITS) - 64'd1));
                held_pos[held_count] = held_count[IDX_W-1:0];
                held_count++;
            end
            if (!last) begin
                return;
            end
            // Stable insertion sort: equal keys keep their arrival order.
            for (int i = 1; i < held_count; i++) begin
                k = held_key[i];
                p = held_pos[i];
                j = i;
                while (j > 0 && held_key[j-1] > k) begin
                    held_key[j] = held_key[j-1];
                    held_pos[j] = held_pos[j-1];
                    j--;
                end
                held_key[j] = k;
                held_pos[j] = p;
            end
            for (int i = 0; i < held_count; i++) begin
                e.key = held_key[i];
                e.pos = held_pos[i];
                e.fin = (i == held_count - 1);
                owed_sorted.push_back(e);
            end
            held_count = 0;
        endfunction

        // Compare one sorted transaction with the oldest prediction.
        function void check_sorted(logic [KEY_PORT_W-1:0] key, logic [IDX_W-1:0] pos,
                                   logic fin);
            t_sorted_entry e;
            if (owed_sorted.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display("[%0t] unexpected result: key %h index %0d final %b",
                             $realtime, key, pos, fin);
                end
                return;
            end
            e = owed_sorted.pop_front();
            if (key !== e.key || pos !== e.pos || fin !== e.fin) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT) begin
                    $display({"[%0t] mismatch: expected key %h index %0d final %b,",
                              " got key %h index %0d final %b"},
                             $realtime, e.key, e.pos, e.fin, key, pos, fin);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [KEY_PORT_W-1:0] i_key;
    logic                  i_last;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [KEY_PORT_W-1:0] o_sorted_key;
    logic [IDX_W-1:0]      o_original_index;
    logic                  o_final_res;

    sorted_run_checker board;
    bit                quiet_phase = 1'b0;
    int                idle_cycles = 0;
    int                items_sent  = 0;
    bit                moved;

    key_sort_engine uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_key            (i_key),
        .i_last           (i_last),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_sorted_key     (o_sorted_key),
        .o_original_index (o_original_index),
        .o_final_res      (o_final_res)
    );

    always #5 i_clk = ~i_clk;

    // Offer one key, sometimes after an idle burst, and wait for its handshake.
    // The stall seen at the falling edge is the one in force at the next rising edge.
    task automatic feed_key(logic [KEY_PORT_W-1:0] key, logic last);
        logic stalled;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_key      <= key;
        i_last     <= last;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled);
        items_sent++;
        if (items_sent >= TOTAL_ITEMS - QUIET_ITEMS) begin
            quiet_phase = 1'b1;
        end
    endtask

    // Random key with a bias towards ties and both ends of the range.
    function automatic logic [KEY_PORT_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0: begin
                return $urandom_range(0, 3);
            end
            1: begin
                return 32'hFFFF_FFFF - $urandom_range(0, 3);
            end
            default: begin
                return $urandom();
            end
        endcase
    endfunction

    // Output stall bursts; none once the quiet phase starts.
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            if (!quiet_phase && $urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // Observe both channels at the falling edge, where every signal already holds
    // the value seen by the next rising edge; input first so a set is complete
    // before its results.
    always @(negedge i_clk) begin
        moved = 1'b0;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            board.load_key(i_key, i_last);
            moved = 1'b1;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_sorted(o_sorted_key, o_original_index, o_final_res);
            moved = 1'b1;
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Stimulus: directed sets, then random sets, then drain.
    initial begin
        int set_size;
        board = new();
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_key      <= '0;
        i_last     <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Single-key sets at both ends of the key range.
        feed_key(32'h0000_0000, 1'b1);
        feed_key(32'hFFFF_FFFF, 1'b1);
        // Extremes mixed together.
        feed_key(32'hFFFF_FFFF, 1'b0);
        feed_key(32'h0000_0000, 1'b0);
        feed_key(32'h8000_0000, 1'b0);
        feed_key(32'h7FFF_FFFF, 1'b0);
        feed_key(32'h0000_0001, 1'b1);
        // Equal keys must leave in arrival order.
        feed_key(32'd5, 1'b0);
        feed_key(32'd5, 1'b0);
        feed_key(32'd3, 1'b0);
        feed_key(32'd5, 1'b0);
        feed_key(32'd3, 1'b1);
        // Fully reversed input.
        for (int i = 9; i >= 4; i--) begin
            feed_key(i, i == 4);
        end
        // Already in order.
        for (int i = 1; i <= 3; i++) begin
            feed_key(i, i == 3);
        end

        // Random sets; the first overfills the store so that the extra keys,
        // the last-marked one among them, are dropped.
        set_size = STORE_DEPTH + 2;
        while (items_sent < TOTAL_ITEMS) begin
            // The final set is trimmed so the run ends at the planned item count.
            if (set_size > TOTAL_ITEMS - items_sent) begin
                set_size = TOTAL_ITEMS - items_sent;
            end
            for (int i = 0; i < set_size; i++) begin
                feed_key(pick_key(), i == set_size - 1);
            end
            if ($urandom_range(0, 11) == 0) begin
                set_size = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 6);
            end else begin
                set_size = $urandom_range(1, 12);
            end
        end
        i_in_valid <= 1'b0;

        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.fault_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/ksort_pkg.sv
src/ksort_cell.sv
src/key_sort_engine.sv
tb/sv/tb_key_sort_engine.sv
